/* src/ecr_pkg.sv */
// Shared constants, beat payload types and rounding helpers for the 2D elastic
// collision pipeline. No dependencies; the divider, square root and top level import this package.
package ecr_pkg;

    // Unit vector and rounding scale (Q2.28).
    localparam int UNIT_BITS = 28;
    // Centre offset is normalized so its larger magnitude has this top bit.
    localparam int NORM_TOP = 19;
    localparam int NORM_BITS = NORM_TOP + 1;

    // Square root of the normalized squared length.
    localparam int SQRT_BITS = 21;
    localparam int SQRT_STEPS_PER_STAGE = 3;

    // Dividers: unit vector (divisor is the length) and mass weights.
    localparam int NDIV_QBITS = 29;
    localparam int NDIV_DBITS = 21;
    localparam int WDIV_QBITS = 34;
    localparam int WDIV_DBITS = 17;
    localparam int DIV_STEPS_PER_STAGE = 4;

    // Original velocities, carried alongside the math.
    typedef struct packed {
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
    } vel_t;

    // Geometry side data carried through the square root and unit dividers.
    typedef struct packed {
        logic signed [32:0] ux;
        logic signed [32:0] uy;
        logic signed [20:0] px;
        logic signed [20:0] py;
        vel_t               vel;
        logic [15:0]        m1;
        logic [15:0]        m2;
        logic               hit;
    } geo_t;

    // Side data carried through the weight dividers.
    typedef struct packed {
        vel_t               vel;
        logic signed [29:0] nx;
        logic signed [29:0] ny;
        logic signed [34:0] v;
        logic               hit;
    } post_t;

    // Divide by 2^UNIT_BITS, rounding to nearest with ties away from zero.
    function automatic logic signed [65:0] round_shift(input logic signed [65:0] a);
        logic [65:0] m;
        m = a[65] ? 66'(-a) : 66'(a);
        m = (m + (66'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
        return a[65] ? -$signed(m) : $signed(m);
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [39:0] a);
        logic [31:0] r;
        if (a > 40'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (a < -40'sd2147483648)
            r = 32'h8000_0000;
        else
            r = a[31:0];
        return r;
    endfunction

endpackage

/* src/ecr_udiv.sv */
// Pipelined unsigned restoring divider with a side payload that travels with each beat.
// Depends on ecr_pkg for default widths and step counts.
module ecr_udiv #(
    parameter int QW  = ecr_pkg::NDIV_QBITS,
    parameter int DW  = ecr_pkg::NDIV_DBITS,
    parameter int SW  = 1,
    parameter int BPS = ecr_pkg::DIV_STEPS_PER_STAGE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [QW+DW-1:0]  num,
    input  logic [DW-1:0]     den,
    input  logic [SW-1:0]     side_in,
    output logic              out_vld,
    output logic [QW-1:0]     quo,
    output logic [SW-1:0]     side_out
);
    import ecr_pkg::*;

    localparam int NS = (QW + BPS - 1) / BPS;

    logic [DW-1:0] rem_reg  [NS];
    logic [QW-1:0] qn_reg   [NS];
    logic [DW-1:0] den_reg  [NS];
    logic [SW-1:0] side_reg [NS];
    logic          vld_reg  [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_st
        logic [DW-1:0] rem_i;
        logic [QW-1:0] qn_i;
        logic [DW-1:0] den_i;
        logic [SW-1:0] side_i;
        logic          vld_i;
        logic [DW-1:0] rem_o;
        logic [QW-1:0] qn_o;

        // The quotient is known to fit in QW bits, so the top bits start as remainder.
        if (s == 0)
        begin : g_first
            assign rem_i  = num[QW+DW-1:QW];
            assign qn_i   = num[QW-1:0];
            assign den_i  = den;
            assign side_i = side_in;
            assign vld_i  = in_vld;
        end
        else
        begin : g_next
            assign rem_i  = rem_reg[s-1];
            assign qn_i   = qn_reg[s-1];
            assign den_i  = den_reg[s-1];
            assign side_i = side_reg[s-1];
            assign vld_i  = vld_reg[s-1];
        end

        // Up to BPS restoring steps per stage; quotient bits shift in as numerator bits shift out.
        always_comb
        begin
            logic [DW:0] t;
            t     = '0;
            rem_o = rem_i;
            qn_o  = qn_i;
            for (int j = 0; j < BPS; j++)
            begin
                if (s * BPS + j < QW)
                begin
                    t = {rem_o, qn_o[QW-1]};
                    if (t >= {1'b0, den_i})
                    begin
                        t    = t - {1'b0, den_i};
                        qn_o = {qn_o[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        qn_o = {qn_o[QW-2:0], 1'b0};
                    end
                    rem_o = t[DW-1:0];
                end
            end
        end

        // Stage valid.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_i;
        end

        // Stage payload.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_o;
                qn_reg[s]   <= qn_o;
                den_reg[s]  <= den_i;
                side_reg[s] <= side_i;
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign quo      = qn_reg[NS-1];
    assign side_out = side_reg[NS-1];

endmodule

/* src/ecr_isqrt.sv */
// Pipelined integer square root (floor), two radicand bits per step, with side payload.
// Depends on ecr_pkg for default sizes.
module ecr_isqrt #(
    parameter int RW  = ecr_pkg::SQRT_BITS,
    parameter int SW  = 1,
    parameter int BPS = ecr_pkg::SQRT_STEPS_PER_STAGE
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [2*RW-1:0] x,
    input  logic [SW-1:0]   side_in,
    output logic            out_vld,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   side_out
);
    import ecr_pkg::*;

    localparam int NS = (RW + BPS - 1) / BPS;

    logic [RW+1:0]   rem_reg  [NS];
    logic [RW-1:0]   res_reg  [NS];
    logic [2*RW-1:0] xs_reg   [NS];
    logic [SW-1:0]   side_reg [NS];
    logic            vld_reg  [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_st
        logic [RW+1:0]   rem_i;
        logic [RW-1:0]   res_i;
        logic [2*RW-1:0] xs_i;
        logic [SW-1:0]   side_i;
        logic            vld_i;
        logic [RW+1:0]   rem_o;
        logic [RW-1:0]   res_o;
        logic [2*RW-1:0] xs_o;

        if (s == 0)
        begin : g_first
            assign rem_i  = '0;
            assign res_i  = '0;
            assign xs_i   = x;
            assign side_i = side_in;
            assign vld_i  = in_vld;
        end
        else
        begin : g_next
            assign rem_i  = rem_reg[s-1];
            assign res_i  = res_reg[s-1];
            assign xs_i   = xs_reg[s-1];
            assign side_i = side_reg[s-1];
            assign vld_i  = vld_reg[s-1];
        end

        // Digit-by-digit root: try appending a one bit, keep it if the remainder allows.
        always_comb
        begin
            logic [RW+3:0] t;
            logic [RW+3:0] trial;
            t     = '0;
            trial = '0;
            rem_o = rem_i;
            res_o = res_i;
            xs_o  = xs_i;
            for (int j = 0; j < BPS; j++)
            begin
                if (s * BPS + j < RW)
                begin
                    t     = {rem_o, xs_o[2*RW-1:2*RW-2]};
                    trial = (RW + 4)'({res_o, 2'b01});
                    if (t >= trial)
                    begin
                        t     = t - trial;
                        res_o = {res_o[RW-2:0], 1'b1};
                    end
                    else
                    begin
                        res_o = {res_o[RW-2:0], 1'b0};
                    end
                    rem_o = t[RW+1:0];
                    xs_o  = {xs_o[2*RW-3:0], 2'b00};
                end
            end
        end

        // Stage valid.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_i;
        end

        // Stage payload.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_o;
                res_reg[s]  <= res_o;
                xs_reg[s]   <= xs_o;
                side_reg[s] <= side_i;
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign root     = res_reg[NS-1];
    assign side_out = side_reg[NS-1];

endmodule

/* src/elastic_collision_response_2d.sv */
// Throughput: one body pair per cycle; the square root and the four dividers are fully
// pipelined, so every stage takes a new beat each cycle while the output is not stalled.
// A stalled output freezes the whole pipeline in place and holds off the input.
// Reset (rst_n low, asynchronous) clears every stage valid; payload registers are not reset.
module elastic_collision_response_2d (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] first_pos_x,
    input  logic signed [31:0] first_pos_y,
    input  logic signed [31:0] first_vel_x,
    input  logic signed [31:0] first_vel_y,
    input  logic signed [31:0] second_pos_x,
    input  logic signed [31:0] second_pos_y,
    input  logic signed [31:0] second_vel_x,
    input  logic signed [31:0] second_vel_y,
    input  logic [15:0]        first_mass,
    input  logic [15:0]        second_mass,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               collided,
    output logic signed [31:0] new_first_vel_x,
    output logic signed [31:0] new_first_vel_y,
    output logic signed [31:0] new_second_vel_x,
    output logic signed [31:0] new_second_vel_y,
    output logic signed [31:0] closing_speed
);
    import ecr_pkg::*;

    // Global advance: everything moves unless a finished beat is held at the output.
    logic en;
    logic result_valid_reg;
    assign en         = !(result_valid_reg && result_stall);
    assign item_stall = !en;

    // Stage A: relative velocity and position.
    logic               a_vld_reg;
    logic signed [32:0] a_ux_reg, a_uy_reg, a_rx_reg, a_ry_reg;
    vel_t               a_vel_reg;
    logic [15:0]        a_m1_reg, a_m2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ux_reg      <= 33'(first_vel_x) - 33'(second_vel_x);
            a_uy_reg      <= 33'(first_vel_y) - 33'(second_vel_y);
            a_rx_reg      <= 33'(first_pos_x) - 33'(second_pos_x);
            a_ry_reg      <= 33'(first_pos_y) - 33'(second_pos_y);
            a_vel_reg.v1x <= first_vel_x;
            a_vel_reg.v1y <= first_vel_y;
            a_vel_reg.v2x <= second_vel_x;
            a_vel_reg.v2y <= second_vel_y;
            a_m1_reg      <= first_mass;
            a_m2_reg      <= second_mass;
        end
    end

    // Stage B: normalize the centre offset so its larger magnitude has its top bit at NORM_TOP.
    logic signed [32:0]          rx_fix;
    logic [32:0]                 ax, ay, big;
    logic [5:0]                  lead;
    logic [32+NORM_BITS-1:0]     shx, shy;
    logic signed [20:0]          px_n, py_n;

    always_comb
    begin
        // Coincident centres use the +x axis.
        rx_fix = (a_rx_reg == 33'sd0 && a_ry_reg == 33'sd0) ? 33'sd1 : a_rx_reg;
        ax     = rx_fix[32] ? 33'(-rx_fix) : 33'(rx_fix);
        ay     = a_ry_reg[32] ? 33'(-a_ry_reg) : 33'(a_ry_reg);
        big    = (ax > ay) ? ax : ay;
        lead   = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (big[i])
                lead = 6'(i);
        end
        shx  = {ax, {NORM_TOP{1'b0}}} >> lead;
        shy  = {ay, {NORM_TOP{1'b0}}} >> lead;
        px_n = rx_fix[32] ? -$signed({1'b0, shx[NORM_BITS-1:0]})
                          : $signed({1'b0, shx[NORM_BITS-1:0]});
        py_n = a_ry_reg[32] ? -$signed({1'b0, shy[NORM_BITS-1:0]})
                            : $signed({1'b0, shy[NORM_BITS-1:0]});
    end

    logic               b_vld_reg;
    logic signed [32:0] b_ux_reg, b_uy_reg;
    logic signed [20:0] b_px_reg, b_py_reg;
    vel_t               b_vel_reg;
    logic [15:0]        b_m1_reg, b_m2_reg;
    logic               b_still_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_ux_reg    <= a_ux_reg;
            b_uy_reg    <= a_uy_reg;
            b_px_reg    <= px_n;
            b_py_reg    <= py_n;
            b_vel_reg   <= a_vel_reg;
            b_m1_reg    <= a_m1_reg;
            b_m2_reg    <= a_m2_reg;
            b_still_reg <= (a_ux_reg == 33'sd0) && (a_uy_reg == 33'sd0);
        end
    end

    // Stage C: approach-test products and squared components.
    logic               c_vld_reg;
    logic signed [53:0] c_dotx_reg, c_doty_reg;
    logic signed [41:0] c_sqx_reg, c_sqy_reg;
    geo_t               c_geo_reg;
    logic               c_still_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_dotx_reg    <= 54'(b_ux_reg) * 54'(b_px_reg);
            c_doty_reg    <= 54'(b_uy_reg) * 54'(b_py_reg);
            c_sqx_reg     <= 42'(b_px_reg) * 42'(b_px_reg);
            c_sqy_reg     <= 42'(b_py_reg) * 42'(b_py_reg);
            c_geo_reg.ux  <= b_ux_reg;
            c_geo_reg.uy  <= b_uy_reg;
            c_geo_reg.px  <= b_px_reg;
            c_geo_reg.py  <= b_py_reg;
            c_geo_reg.vel <= b_vel_reg;
            c_geo_reg.m1  <= b_m1_reg;
            c_geo_reg.m2  <= b_m2_reg;
            c_geo_reg.hit <= 1'b0;
            c_still_reg   <= b_still_reg;
        end
    end

    // Stage D: collision decision and squared length for the root.
    logic signed [54:0] dot_sum;
    geo_t               d_geo_next;
    assign dot_sum = 55'(c_dotx_reg) + 55'(c_doty_reg);

    always_comb
    begin
        d_geo_next     = c_geo_reg;
        d_geo_next.hit = !c_still_reg && (dot_sum <= 55'sd0);
    end

    logic        d_vld_reg;
    logic [41:0] d_x_reg;
    geo_t        d_geo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else if (en)
            d_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_x_reg   <= 42'(c_sqx_reg + c_sqy_reg);
            d_geo_reg <= d_geo_next;
        end
    end

    // Length of the normalized offset.
    logic                 s_vld;
    logic [SQRT_BITS-1:0] s_len;
    geo_t                 s_geo;

    ecr_isqrt #(
        .RW  (SQRT_BITS),
        .SW  ($bits(geo_t)),
        .BPS (SQRT_STEPS_PER_STAGE)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (d_vld_reg),
        .x        (d_x_reg),
        .side_in  (d_geo_reg),
        .out_vld  (s_vld),
        .root     (s_len),
        .side_out (s_geo)
    );

    // Stage E: unit vector numerators, magnitude scaled by 2^28 plus half the length.
    logic [20:0] pmx, pmy;
    assign pmx = s_geo.px[20] ? 21'(-s_geo.px) : 21'(s_geo.px);
    assign pmy = s_geo.py[20] ? 21'(-s_geo.py) : 21'(s_geo.py);

    logic                                e_vld_reg;
    logic [NDIV_QBITS+NDIV_DBITS-1:0]    e_numx_reg, e_numy_reg;
    logic [NDIV_DBITS-1:0]               e_len_reg;
    geo_t                                e_geo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (en)
            e_vld_reg <= s_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_numx_reg <= (NDIV_QBITS + NDIV_DBITS)'({pmx[NORM_BITS-1:0], {UNIT_BITS{1'b0}}})
                        + (NDIV_QBITS + NDIV_DBITS)'(s_len >> 1);
            e_numy_reg <= (NDIV_QBITS + NDIV_DBITS)'({pmy[NORM_BITS-1:0], {UNIT_BITS{1'b0}}})
                        + (NDIV_QBITS + NDIV_DBITS)'(s_len >> 1);
            e_len_reg  <= NDIV_DBITS'(s_len);
            e_geo_reg  <= s_geo;
        end
    end

    // Unit vector dividers.
    logic                  nx_vld, ny_vld;
    logic [NDIV_QBITS-1:0] qx, qy;
    geo_t                  nx_geo;
    logic                  ny_neg;

    ecr_udiv #(
        .QW  (NDIV_QBITS),
        .DW  (NDIV_DBITS),
        .SW  ($bits(geo_t)),
        .BPS (DIV_STEPS_PER_STAGE)
    ) u_div_nx (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (e_vld_reg),
        .num      (e_numx_reg),
        .den      (e_len_reg),
        .side_in  (e_geo_reg),
        .out_vld  (nx_vld),
        .quo      (qx),
        .side_out (nx_geo)
    );

    ecr_udiv #(
        .QW  (NDIV_QBITS),
        .DW  (NDIV_DBITS),
        .SW  (1),
        .BPS (DIV_STEPS_PER_STAGE)
    ) u_div_ny (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (e_vld_reg),
        .num      (e_numy_reg),
        .den      (e_len_reg),
        .side_in  (e_geo_reg.py[20]),
        .out_vld  (ny_vld),
        .quo      (qy),
        .side_out (ny_neg)
    );

    // Stage F: signed unit vector.
    logic               f_vld_reg;
    logic signed [29:0] f_nx_reg, f_ny_reg;
    logic signed [32:0] f_ux_reg, f_uy_reg;
    vel_t               f_vel_reg;
    logic [15:0]        f_m1_reg, f_m2_reg;
    logic               f_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (en)
            f_vld_reg <= nx_vld && ny_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_nx_reg  <= nx_geo.px[20] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            f_ny_reg  <= ny_neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            f_ux_reg  <= nx_geo.ux;
            f_uy_reg  <= nx_geo.uy;
            f_vel_reg <= nx_geo.vel;
            f_m1_reg  <= nx_geo.m1;
            f_m2_reg  <= nx_geo.m2;
            f_hit_reg <= nx_geo.hit;
        end
    end

    // Stage G: head-on speed products.
    logic               g_vld_reg;
    logic signed [62:0] g_dx_reg, g_dy_reg;
    logic signed [29:0] g_nx_reg, g_ny_reg;
    vel_t               g_vel_reg;
    logic [15:0]        g_m1_reg, g_m2_reg;
    logic               g_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_vld_reg <= 1'b0;
        else if (en)
            g_vld_reg <= f_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_dx_reg  <= 63'(f_ux_reg) * 63'(f_nx_reg);
            g_dy_reg  <= 63'(f_uy_reg) * 63'(f_ny_reg);
            g_nx_reg  <= f_nx_reg;
            g_ny_reg  <= f_ny_reg;
            g_vel_reg <= f_vel_reg;
            g_m1_reg  <= f_m1_reg;
            g_m2_reg  <= f_m2_reg;
            g_hit_reg <= f_hit_reg;
        end
    end

    // Stage H: rounded head-on speed and mass weights.
    logic signed [63:0] hv_sum;
    logic [16:0]        msum;
    logic               mzero;
    assign hv_sum = 64'(g_dx_reg) + 64'(g_dy_reg);
    assign msum   = {1'b0, g_m1_reg} + {1'b0, g_m2_reg};
    assign mzero  = (msum == 17'd0);

    logic                  h_vld_reg;
    logic signed [34:0]    h_v_reg;
    logic [WDIV_DBITS-1:0] h_c1_reg, h_c2_reg, h_den_reg;
    logic signed [29:0]    h_nx_reg, h_ny_reg;
    vel_t                  h_vel_reg;
    logic                  h_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_vld_reg <= 1'b0;
        else if (en)
            h_vld_reg <= g_vld_reg;
    end

    // Both masses zero: particle form, so the first weight is 2*v and the second zero.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_v_reg   <= 35'(round_shift(66'(hv_sum)));
            h_c1_reg  <= mzero ? WDIV_DBITS'(2) : {g_m2_reg, 1'b0};
            h_c2_reg  <= mzero ? '0 : {g_m1_reg, 1'b0};
            h_den_reg <= mzero ? WDIV_DBITS'(1) : msum;
            h_nx_reg  <= g_nx_reg;
            h_ny_reg  <= g_ny_reg;
            h_vel_reg <= g_vel_reg;
            h_hit_reg <= g_hit_reg;
        end
    end

    // Stage I: weight numerator products.
    logic [33:0] vmag;
    assign vmag = h_v_reg[34] ? 34'(-h_v_reg) : 34'(h_v_reg);

    logic                              i_vld_reg;
    logic [WDIV_QBITS+WDIV_DBITS-1:0]  i_p1_reg, i_p2_reg;
    logic [WDIV_DBITS-1:0]             i_den_reg;
    post_t                             i_post_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            i_vld_reg <= 1'b0;
        else if (en)
            i_vld_reg <= h_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_p1_reg       <= (WDIV_QBITS + WDIV_DBITS)'(h_c1_reg * vmag);
            i_p2_reg       <= (WDIV_QBITS + WDIV_DBITS)'(h_c2_reg * vmag);
            i_den_reg      <= h_den_reg;
            i_post_reg.vel <= h_vel_reg;
            i_post_reg.nx  <= h_nx_reg;
            i_post_reg.ny  <= h_ny_reg;
            i_post_reg.v   <= h_v_reg;
            i_post_reg.hit <= h_hit_reg;
        end
    end

    // Stage J: add half the divisor for round-to-nearest.
    logic                              j_vld_reg;
    logic [WDIV_QBITS+WDIV_DBITS-1:0]  j_num1_reg, j_num2_reg;
    logic [WDIV_DBITS-1:0]             j_den_reg;
    post_t                             j_post_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_vld_reg <= 1'b0;
        else if (en)
            j_vld_reg <= i_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_num1_reg <= i_p1_reg + (WDIV_QBITS + WDIV_DBITS)'(i_den_reg >> 1);
            j_num2_reg <= i_p2_reg + (WDIV_QBITS + WDIV_DBITS)'(i_den_reg >> 1);
            j_den_reg  <= i_den_reg;
            j_post_reg <= i_post_reg;
        end
    end

    // Weight dividers.
    logic                  w1_vld, w2_vld;
    logic [WDIV_QBITS-1:0] qw1, qw2;
    post_t                 w_post;
    logic                  w2_neg;

    ecr_udiv #(
        .QW  (WDIV_QBITS),
        .DW  (WDIV_DBITS),
        .SW  ($bits(post_t)),
        .BPS (DIV_STEPS_PER_STAGE)
    ) u_div_w1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (j_vld_reg),
        .num      (j_num1_reg),
        .den      (j_den_reg),
        .side_in  (j_post_reg),
        .out_vld  (w1_vld),
        .quo      (qw1),
        .side_out (w_post)
    );

    ecr_udiv #(
        .QW  (WDIV_QBITS),
        .DW  (WDIV_DBITS),
        .SW  (1),
        .BPS (DIV_STEPS_PER_STAGE)
    ) u_div_w2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (j_vld_reg),
        .num      (j_num2_reg),
        .den      (j_den_reg),
        .side_in  (j_post_reg.v[34]),
        .out_vld  (w2_vld),
        .quo      (qw2),
        .side_out (w2_neg)
    );

    // Stage K: signed weights.
    logic               k_vld_reg;
    logic signed [34:0] k_w1_reg, k_w2_reg;
    post_t              k_post_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_vld_reg <= 1'b0;
        else if (en)
            k_vld_reg <= w1_vld && w2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_w1_reg   <= w_post.v[34] ? -$signed({1'b0, qw1}) : $signed({1'b0, qw1});
            k_w2_reg   <= w2_neg ? -$signed({1'b0, qw2}) : $signed({1'b0, qw2});
            k_post_reg <= w_post;
        end
    end

    // Stage L: velocity change products.
    logic               l_vld_reg;
    logic signed [64:0] l_d1x_reg, l_d1y_reg, l_d2x_reg, l_d2y_reg;
    vel_t               l_vel_reg;
    logic signed [34:0] l_v_reg;
    logic               l_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l_vld_reg <= 1'b0;
        else if (en)
            l_vld_reg <= k_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_d1x_reg <= 65'(k_w1_reg) * 65'(k_post_reg.nx);
            l_d1y_reg <= 65'(k_w1_reg) * 65'(k_post_reg.ny);
            l_d2x_reg <= 65'(k_w2_reg) * 65'(k_post_reg.nx);
            l_d2y_reg <= 65'(k_w2_reg) * 65'(k_post_reg.ny);
            l_vel_reg <= k_post_reg.vel;
            l_v_reg   <= k_post_reg.v;
            l_hit_reg <= k_post_reg.hit;
        end
    end

    // Stage M: round the changes, apply them and saturate into the output register.
    logic signed [36:0] d1x, d1y, d2x, d2y;
    assign d1x = 37'(round_shift(66'(l_d1x_reg)));
    assign d1y = 37'(round_shift(66'(l_d1y_reg)));
    assign d2x = 37'(round_shift(66'(l_d2x_reg)));
    assign d2y = 37'(round_shift(66'(l_d2y_reg)));

    logic        collided_reg;
    logic [31:0] nv1x_reg, nv1y_reg, nv2x_reg, nv2y_reg, closing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (en)
            result_valid_reg <= l_vld_reg;
    end

    // A pair that is not approaching passes its velocities through unchanged.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            collided_reg <= l_hit_reg;
            if (l_hit_reg)
            begin
                nv1x_reg    <= sat32(40'(l_vel_reg.v1x) - 40'(d1x));
                nv1y_reg    <= sat32(40'(l_vel_reg.v1y) - 40'(d1y));
                nv2x_reg    <= sat32(40'(l_vel_reg.v2x) + 40'(d2x));
                nv2y_reg    <= sat32(40'(l_vel_reg.v2y) + 40'(d2y));
                closing_reg <= sat32(40'(l_v_reg));
            end
            else
            begin
                nv1x_reg    <= l_vel_reg.v1x;
                nv1y_reg    <= l_vel_reg.v1y;
                nv2x_reg    <= l_vel_reg.v2x;
                nv2y_reg    <= l_vel_reg.v2y;
                closing_reg <= '0;
            end
        end
    end

    assign result_valid     = result_valid_reg;
    assign collided         = collided_reg;
    assign new_first_vel_x  = nv1x_reg;
    assign new_first_vel_y  = nv1y_reg;
    assign new_second_vel_x = nv2x_reg;
    assign new_second_vel_y = nv2y_reg;
    assign closing_speed    = closing_reg;

endmodule

/* src/ecr_check.sv */
// Port-level checker for the collision pipeline, bound to the top level by the bind below.
// Depends on the top level's port names only.
module ecr_check (
    input logic               clk,
    input logic               rst_n,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input logic               collided,
    input logic signed [31:0] new_first_vel_x,
    input logic signed [31:0] closing_speed
);

    // Input is held off only while a finished beat waits at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled without a held output beat");

    // A pair with no collision reports zero closing speed.
    a_no_hit_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !collided) |-> (closing_speed == 32'sd0))
        else $error("closing speed nonzero without a collision");

    // A new result beat appears only when the pipeline advanced to produce it.
    a_rise_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_stall))
        else $error("result appeared while the pipeline was frozen");

    // A stalled result beat holds its valid, closing speed and first x velocity.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(closing_speed) && $stable(new_first_vel_x)))
        else $error("stalled result beat changed");

endmodule

bind elastic_collision_response_2d ecr_check u_ecr_check (.*);
